// ===== src/bis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded integer set package
// Shared sizes, operation codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bis_pkg;

    // Table size and the widths that follow from it.
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the transactions.
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;
    localparam int CAP_W   = 7;

    // Width used to compare the element count against the capacity limit.
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Capacity limit after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // Operation codes. The unused code behaves as a lookup.
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture a new transaction and restart the scan
        logic scan_issue;  // read the next table entry
        logic hit_set;     // record the match of the entry just read
        logic wr_add;      // append the value and bump the count
        logic rd_last;     // read the last entry and drop the count
        logic wr_move;     // copy the last entry into the hole
        logic out_load;    // load the result register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_add;
        logic is_remove;
        logic match;       // entry read last cycle equals the value
        logic rd_vld;      // a scan read is in flight
        logic scan_done;   // every held entry has been issued
        logic hit;         // value was found in this transaction
        logic can_add;     // value absent and room below the limit and the table size
        logic out_free;    // result register can take a new result
    } t_ctl_stat;

endpackage
`default_nettype wire

// ===== src/bis_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded integer set datapath
// Holds the value table, element count, capacity register, scan pointer and
// the result register. Acts on controller commands and capacity writes.
// ----------------------------------------------------------------------------
module bis_datapath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire bis_pkg::t_ctl_cmd                    i_cmd,
    output bis_pkg::t_ctl_stat                        o_stat,
    input  wire logic                                 i_cfg_we,
    input  wire logic [bis_pkg::CAP_W-1:0]            i_cfg_wdata,
    input  wire logic [bis_pkg::OP_W-1:0]             i_operation,
    input  wire logic signed [bis_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                                 i_out_stall,
    output logic                                      o_out_valid,
    output logic                                      o_found,
    output logic [bis_pkg::POS_W-1:0]                 o_position,
    output logic [bis_pkg::COUNT_W-1:0]               o_element_count
);

    // Value table, written and read through one port each.
    logic [bis_pkg::VALUE_W-1:0] r_mem [bis_pkg::DEPTH];

    logic [bis_pkg::VALUE_W-1:0]        r_rd_data;
    logic                               r_rd_vld;
    logic [bis_pkg::IDX_W-1:0]          r_rd_idx;
    logic [bis_pkg::CNT_W-1:0]          r_scan_idx;
    logic [bis_pkg::CNT_W-1:0]          r_count;
    logic [bis_pkg::CAP_W-1:0]          r_cap;
    logic [bis_pkg::OP_W-1:0]           r_op;
    logic signed [bis_pkg::VALUE_W-1:0] r_value;
    logic                               r_hit;
    logic [bis_pkg::IDX_W-1:0]          r_pos;
    logic                               r_out_vld;
    logic                               r_out_found;
    logic [bis_pkg::POS_W-1:0]          r_out_pos;
    logic [bis_pkg::COUNT_W-1:0]        r_out_count;

    logic [bis_pkg::CNT_W-1:0]          w_last;
    logic [bis_pkg::IDX_W-1:0]          w_rd_addr;
    logic                               w_rd_en;
    logic [bis_pkg::IDX_W-1:0]          w_wr_addr;
    logic [bis_pkg::VALUE_W-1:0]        w_wr_data;
    logic                               w_wr_en;

    // Address of the last held entry.
    assign w_last = r_count - bis_pkg::CNT_W'(1);

    // Table port selection.
    assign w_rd_en   = i_cmd.scan_issue | i_cmd.rd_last;
    assign w_rd_addr = i_cmd.scan_issue ? r_scan_idx[bis_pkg::IDX_W-1:0]
                                        : w_last[bis_pkg::IDX_W-1:0];
    assign w_wr_en   = i_cmd.wr_add | i_cmd.wr_move;
    assign w_wr_addr = i_cmd.wr_add ? r_count[bis_pkg::IDX_W-1:0] : r_pos;
    assign w_wr_data = i_cmd.wr_add ? r_value : r_rd_data;

    // Table storage with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Transaction payload and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
        if (i_cmd.scan_issue) begin
            r_rd_idx <= r_scan_idx[bis_pkg::IDX_W-1:0];
        end
        if (i_cmd.load) begin
            r_pos <= '0;
        end else if (i_cmd.hit_set) begin
            r_pos <= r_rd_idx;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_hit;
            r_out_pos   <= bis_pkg::POS_W'(r_pos);
            r_out_count <= bis_pkg::COUNT_W'(r_count);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cap      <= bis_pkg::CAP_RESET;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.wr_add) begin
                r_count <= r_count + bis_pkg::CNT_W'(1);
            end else if (i_cmd.rd_last) begin
                r_count <= w_last;
            end
            if (i_cmd.load) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan_issue) begin
                r_scan_idx <= r_scan_idx + bis_pkg::CNT_W'(1);
            end
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (i_cmd.hit_set) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.is_add    = (r_op == bis_pkg::OP_ADD);
        o_stat.is_remove = (r_op == bis_pkg::OP_REMOVE);
        o_stat.match     = r_rd_vld && (r_rd_data == r_value);
        o_stat.rd_vld    = r_rd_vld;
        o_stat.scan_done = (r_scan_idx == r_count);
        o_stat.hit       = r_hit;
        o_stat.can_add   = !r_hit
                           && (bis_pkg::CMP_W'(r_count) < bis_pkg::CMP_W'(r_cap))
                           && (r_count < bis_pkg::CNT_W'(bis_pkg::DEPTH));
        o_stat.out_free  = !r_out_vld || !i_out_stall;
    end

    assign o_out_valid     = r_out_vld;
    assign o_found         = r_out_found;
    assign o_position      = r_out_pos;
    assign o_element_count = r_out_count;

    // The element count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bis_pkg::CNT_W'(bis_pkg::DEPTH))
        else $error("element count above table size");

    // The count moves by at most one per cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + bis_pkg::CNT_W'(1))
        || (r_count == $past(r_count) - bis_pkg::CNT_W'(1)))
        else $error("element count jumped");

    // The table is never written while a scan read is issued.
    a_no_wr_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_issue |-> !w_wr_en)
        else $error("table write during scan");

    // A hit is recorded only for an entry that matched.
    a_hit_on_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_set |-> o_stat.match)
        else $error("hit recorded without a match");

endmodule
`default_nettype wire

// ===== src/bis_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded integer set controller
// Sequences one transaction at a time: scan the held entries, apply the add
// or remove, then hand the result to the output register.
// ----------------------------------------------------------------------------
module bis_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire bis_pkg::t_ctl_stat i_stat,
    output bis_pkg::t_ctl_cmd       o_cmd
);

    bis_pkg::t_state r_state;
    bis_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bis_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            bis_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bis_pkg::S_SCAN;
                end
            end
            bis_pkg::S_SCAN: begin
                // Compare the entry read last cycle while issuing the next one.
                if (i_stat.match) begin
                    o_cmd.hit_set = 1'b1;
                    n_state       = bis_pkg::S_DECIDE;
                end else if (i_stat.scan_done && !i_stat.rd_vld) begin
                    n_state = bis_pkg::S_DECIDE;
                end else if (!i_stat.scan_done) begin
                    o_cmd.scan_issue = 1'b1;
                end
            end
            bis_pkg::S_DECIDE: begin
                if (i_stat.is_add && i_stat.can_add) begin
                    o_cmd.wr_add = 1'b1;
                    n_state      = bis_pkg::S_DONE;
                end else if (i_stat.is_remove && i_stat.hit) begin
                    o_cmd.rd_last = 1'b1;
                    n_state       = bis_pkg::S_MOVE;
                end else begin
                    n_state = bis_pkg::S_DONE;
                end
            end
            bis_pkg::S_MOVE: begin
                o_cmd.wr_move = 1'b1;
                n_state       = bis_pkg::S_DONE;
            end
            bis_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bis_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bis_pkg::S_IDLE;
            end
        endcase
    end

    // Only one table write command at a time.
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_add && o_cmd.wr_move))
        else $error("two table writes in one cycle");

    // A move always follows the read of the last entry.
    a_move_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_last |=> o_cmd.wr_move)
        else $error("move without preceding read");

    // A new transaction is loaded only when one is offered and accepted.
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (i_in_valid && !o_in_stall))
        else $error("load without an accepted transaction");

endmodule
`default_nettype wire

// ===== src/bounded_integer_set_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded integer set core
// Set of distinct 32-bit integers kept packed in a 64-entry table, with
// lookup, add and remove transactions and a programmable capacity limit.
//
//   Channel  Direction  Handshake              Payload
//   input    in         i_valid / o_stall      i_operation, i_value
//   output   out        o_valid / i_stall      o_found, o_position,
//                                              o_element_count
//   config   in         i_cfg_we               i_cfg_wdata (capacity limit)
//
// Each transaction has its result loaded before the next is accepted. An
// absent value is compared with every held entry: one table read per cycle
// through the single read port, a compare of the last entry, then decide and
// load the result. A hit stops the scan early, and a remove that hits also
// moves the last entry into the hole.
// Reset is synchronous and active low; it empties the set and sets the
// capacity limit to 64. The table needs no clearing pass.
// A stalled result waits in the output register while the next transaction
// is accepted and scanned.
// ----------------------------------------------------------------------------
module bounded_integer_set_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [bis_pkg::OP_W-1:0]             i_operation,
    input  wire logic signed [bis_pkg::VALUE_W-1:0]   i_value,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic                                      o_found,
    output logic [bis_pkg::POS_W-1:0]                 o_position,
    output logic [bis_pkg::COUNT_W-1:0]               o_element_count,
    input  wire logic                                 i_cfg_we,
    input  wire logic [bis_pkg::CAP_W-1:0]            i_cfg_wdata
);

    bis_pkg::t_ctl_cmd  w_cmd;
    bis_pkg::t_ctl_stat w_stat;

    // Transaction sequencer.
    bis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Table, counters and result register.
    bis_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_found         (o_found),
        .o_position      (o_position),
        .o_element_count (o_element_count)
    );

endmodule
`default_nettype wire

// ===== tb/bounded_integer_set_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded integer set core testbench
// Sends lookup, add and remove transactions under random flow control and
// checks every result against a behavioral copy of the set. Directed tests
// cover the field extremes, every operation code, duplicate and absent
// values, and capacity limits below the count, at zero and above the table
// size. They are followed by random traffic under several capacity limits.
// ----------------------------------------------------------------------------
module bounded_integer_set_core_test;

    localparam logic [bis_pkg::OP_W-1:0]    OP_UNUSED    = 2'd3;
    localparam logic [bis_pkg::VALUE_W-1:0] VALUE_MIN    = 32'h8000_0000;
    localparam logic [bis_pkg::VALUE_W-1:0] VALUE_MAX    = 32'h7FFF_FFFF;
    localparam logic [bis_pkg::VALUE_W-1:0] VALUE_ONES   = 32'hFFFF_FFFF;
    localparam int                          IDLE_LIMIT   = 3000;
    localparam int                          DRAIN_CYCLES = 80;
    localparam int                          CHUNK_ITEMS  = 120;
    localparam int                          POOL_SIZE    = 96;

    typedef struct packed {
        logic                        found;
        logic [bis_pkg::POS_W-1:0]   position;
        logic [bis_pkg::COUNT_W-1:0] element_count;
    } t_set_result;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic [bis_pkg::OP_W-1:0]           i_operation;
    logic signed [bis_pkg::VALUE_W-1:0] i_value;
    logic                               o_valid;
    logic                               i_stall;
    logic                               o_found;
    logic [bis_pkg::POS_W-1:0]          o_position;
    logic [bis_pkg::COUNT_W-1:0]        o_element_count;
    logic                               i_cfg_we;
    logic [bis_pkg::CAP_W-1:0]          i_cfg_wdata;

    // Expected contents of the set and the capacity limit last written.
    logic [bis_pkg::VALUE_W-1:0] held_values [bis_pkg::DEPTH];
    int                          held_count;
    logic [bis_pkg::CAP_W-1:0]   capacity_shadow;

    // Results still owed by the block, oldest first.
    t_set_result                 pending_results [$];

    logic [bis_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
    int                          send_idle_pct;
    int                          recv_idle_pct;
    int                          mismatch_count;
    int                          quiet_cycles = 0;

    bounded_integer_set_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_found         (o_found),
        .o_position      (o_position),
        .o_element_count (o_element_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Applies one transaction to the expected set and returns its result.
    function automatic t_set_result apply_set_op(input logic [bis_pkg::OP_W-1:0] op,
                                                 input logic [bis_pkg::VALUE_W-1:0] v);
        t_set_result r;
        int          limit;
        bit          hit;
        int          where;
        hit = 1'b0;
        where = 0;
        limit = (int'(capacity_shadow) < bis_pkg::DEPTH) ? int'(capacity_shadow)
                                                          : bis_pkg::DEPTH;
        for (int i = 0; i < held_count; i++) begin
            if (!hit && held_values[i] == v) begin
                hit = 1'b1;
                where = i;
            end
        end
        case (op)
            bis_pkg::OP_ADD: begin
                if (!hit && held_count < limit) begin
                    held_values[held_count] = v;
                    held_count++;
                end
            end
            bis_pkg::OP_REMOVE: begin
                // The last entry fills the hole left by the removed one.
                if (hit) begin
                    held_count--;
                    held_values[where] = held_values[held_count];
                end
            end
            default: begin
            end
        endcase
        r.found = hit;
        r.position = bis_pkg::POS_W'(where);
        r.element_count = bis_pkg::COUNT_W'(held_count);
        return r;
    endfunction

    // Offers one transaction, with random gaps before it, and records the
    // expected result once it is accepted.
    task automatic send_item(input logic [bis_pkg::OP_W-1:0] op,
                             input logic [bis_pkg::VALUE_W-1:0] v);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            i_operation = bis_pkg::OP_W'($urandom);
            i_value = $urandom;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_operation = op;
        i_value = v;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_results.push_back(apply_set_op(op, v));
    endtask

    // Stops sending and waits until every owed result has been taken.
    task automatic settle_block();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes the capacity limit while the block is idle.
    task automatic write_capacity(input logic [bis_pkg::CAP_W-1:0] cap);
        settle_block();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = cap;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        capacity_shadow = cap;
    endtask

    // Draws a value: mostly held ones or ones from a small pool, so that
    // hits, duplicates and removes are frequent.
    function automatic logic [bis_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45 && held_count > 0) return held_values[$urandom_range(held_count - 1)];
        if (r < 85) return value_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [bis_pkg::OP_W-1:0] pick_operation(input int add_pct,
                                                                input int remove_pct);
        int r;
        r = $urandom_range(99);
        if (r < 5) return OP_UNUSED;
        if (r < 5 + add_pct) return bis_pkg::OP_ADD;
        if (r < 5 + add_pct + remove_pct) return bis_pkg::OP_REMOVE;
        return bis_pkg::OP_LOOKUP;
    endfunction

    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            case ($urandom_range(3))
                0: value_pool[i] = VALUE_MIN + $urandom_range(7);
                1: value_pool[i] = VALUE_MAX - $urandom_range(7);
                2: value_pool[i] = $urandom_range(15) - 8;
                default: value_pool[i] = $urandom;
            endcase
        end
    endtask

    // Random traffic in bursts that lean toward filling, emptying or neither.
    task automatic run_random_traffic(input int items);
        int burst_left;
        int add_pct;
        int remove_pct;
        refresh_pool();
        burst_left = 0;
        add_pct = 35;
        remove_pct = 35;
        for (int n = 0; n < items; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 40);
                case ($urandom_range(2))
                    0: begin
                        add_pct = 65;
                        remove_pct = 15;
                    end
                    1: begin
                        add_pct = 15;
                        remove_pct = 60;
                    end
                    default: begin
                        add_pct = 35;
                        remove_pct = 35;
                    end
                endcase
            end
            burst_left--;
            send_item(pick_operation(add_pct, remove_pct), pick_value());
        end
    endtask

    // Every operation on the extremes of the value field, duplicates,
    // absent values and the unused operation code.
    task automatic test_set_operations();
        send_item(bis_pkg::OP_LOOKUP, 32'd5);
        send_item(bis_pkg::OP_ADD, VALUE_MIN);
        send_item(bis_pkg::OP_ADD, VALUE_MAX);
        send_item(bis_pkg::OP_ADD, 32'd0);
        send_item(bis_pkg::OP_ADD, VALUE_ONES);
        send_item(bis_pkg::OP_ADD, 32'h5555_5555);
        send_item(bis_pkg::OP_ADD, 32'hAAAA_AAAA);
        send_item(bis_pkg::OP_ADD, VALUE_ONES);
        send_item(bis_pkg::OP_LOOKUP, VALUE_MAX);
        send_item(OP_UNUSED, VALUE_MIN);
        send_item(OP_UNUSED, 32'd7);
        send_item(bis_pkg::OP_REMOVE, 32'd0);
        send_item(bis_pkg::OP_LOOKUP, 32'hAAAA_AAAA);
        send_item(bis_pkg::OP_REMOVE, 32'd12345);
        send_item(bis_pkg::OP_REMOVE, 32'h5555_5555);
        send_item(bis_pkg::OP_REMOVE, VALUE_MIN);
        send_item(bis_pkg::OP_LOOKUP, VALUE_ONES);
    endtask

    // Limit lowered below the count: adds are refused until removes make room.
    task automatic test_capacity_below_count();
        write_capacity(bis_pkg::CAP_W'(2));
        send_item(bis_pkg::OP_ADD, 32'd9);
        send_item(bis_pkg::OP_LOOKUP, VALUE_MAX);
        send_item(bis_pkg::OP_REMOVE, VALUE_MAX);
        send_item(bis_pkg::OP_ADD, 32'd9);
        send_item(bis_pkg::OP_REMOVE, 32'hAAAA_AAAA);
        send_item(bis_pkg::OP_ADD, 32'd9);
        send_item(bis_pkg::OP_ADD, 32'd10);
    endtask

    // A zero limit refuses every add but still allows lookups and removes.
    task automatic test_capacity_zero();
        write_capacity(bis_pkg::CAP_W'(0));
        send_item(bis_pkg::OP_ADD, 32'd11);
        send_item(bis_pkg::OP_REMOVE, 32'd9);
        send_item(bis_pkg::OP_ADD, 32'd9);
        send_item(bis_pkg::OP_LOOKUP, VALUE_ONES);
    endtask

    // A limit above the table size stops at the table size.
    task automatic test_capacity_above_table();
        write_capacity({bis_pkg::CAP_W{1'b1}});
        while (held_count < bis_pkg::DEPTH) send_item(bis_pkg::OP_ADD, $urandom);
        send_item(bis_pkg::OP_ADD, 32'h1234_5678);
        send_item(bis_pkg::OP_ADD, held_values[bis_pkg::DEPTH-1]);
        send_item(bis_pkg::OP_LOOKUP, held_values[bis_pkg::DEPTH-1]);
        send_item(bis_pkg::OP_REMOVE, held_values[10]);
    endtask

    // Random traffic under each flow-control mix and several limits.
    task automatic test_random_phases();
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 65 : 0;
            recv_idle_pct = (mode == 0) ? 65 : (mode == 1) ? 21 : 0;
            for (int chunk = 0; chunk < 4; chunk++) begin
                case (chunk)
                    0: write_capacity(bis_pkg::CAP_W'(64));
                    1: write_capacity({bis_pkg::CAP_W{1'b1}});
                    2: write_capacity(bis_pkg::CAP_W'($urandom_range(1, 63)));
                    default: write_capacity(bis_pkg::CAP_W'($urandom_range(0, 6)));
                endcase
                run_random_traffic(CHUNK_ITEMS);
            end
        end
    endtask

    // Receiver flow control.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_set_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, found %0d position %0d count %0d",
                         $time, o_found, o_position, o_element_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch, expected %0d, actual %0d",
                             $time, want.found, o_found);
                    mismatch_count++;
                end
                if (o_position !== want.position) begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want.position, o_position);
                    mismatch_count++;
                end
                if (o_element_count !== want.element_count) begin
                    $display("%0t: element_count mismatch, expected %0d, actual %0d",
                             $time, want.element_count, o_element_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when no transaction moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = bis_pkg::OP_LOOKUP;
        i_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        mismatch_count = 0;
        send_idle_pct = 21;
        recv_idle_pct = 65;
        held_count = 0;
        capacity_shadow = bis_pkg::CAP_RESET;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_set_operations();
        test_capacity_below_count();
        test_capacity_zero();
        test_capacity_above_table();
        test_random_phases();

        // Let any stray result show up before the verdict.
        settle_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bis_pkg.sv
src/bis_datapath.sv
src/bis_ctrl.sv
src/bounded_integer_set_core.sv
tb/bounded_integer_set_core_test.sv
